// File: hdl/olt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_pkg: shared types for the ordered list table
// The action codes and the command token that walks down the row of cells.
// ----------------------------------------------------------------------------
package olt_pkg;

    localparam int KEY_W = 32;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_FIND   = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    // Command token: one action in flight, plus the match seen so far
    typedef struct packed {
        logic             vld;
        t_action          act;
        logic [KEY_W-1:0] key;
        logic             found;
    } t_token;

endpackage

// File: hdl/ordered_list_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_table: bounded insertion-ordered list of 32-bit keys
// Insert, remove-first-match, find and clear over a row of key cells.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its action walks the
// row of CAPACITY cells one cell per clock, and the result strobe o_strobe
// is registered once the token leaves the last cell; busy stays high until
// that cycle, and the next item may be started in the strobe cycle and is
// taken at the edge that ends it; no item is taken while one is in flight.
// The result is shown for one cycle only and cannot be held off by the
// receiver.
// ----------------------------------------------------------------------------
module ordered_list_table #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_key,
    output logic               o_strobe,
    output logic               o_hit,
    output logic               o_dropped,
    output logic               o_is_empty,
    output logic signed [31:0] o_head_key,
    output logic [4:0]         o_count
);
    import olt_pkg::*;

    localparam int FILL_W = $clog2(CAPACITY + 1);

    t_token             w_tok [CAPACITY+1];
    logic [KEY_W-1:0]   w_key [CAPACITY];
    t_token             r_inj;
    logic               r_busy;
    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  n_fill;
    logic               n_hit;
    logic               n_dropped;
    logic [FILL_W+4:0]  w_fill_ext;
    logic               w_accept;
    t_token             w_done;
    logic               r_strobe;
    logic               r_hit;
    logic               r_dropped;
    logic               r_is_empty;
    logic [KEY_W-1:0]   r_head_key;
    logic [4:0]         r_count;

    assign w_accept = start && !r_busy;
    assign w_tok[0] = r_inj;
    assign w_done   = w_tok[CAPACITY];

    // Row of cells; each pulls from its right neighbor on removal
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_W-1:0] w_next;
        if (g < CAPACITY - 1) begin : g_mid
            assign w_next = w_key[g+1];
        end else begin : g_last
            assign w_next = w_key[g];
        end
        olt_cell #(
            .INDEX  (g),
            .FILL_W (FILL_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tok      (w_tok[g]),
            .i_fill     (r_fill),
            .i_next_key (w_next),
            .o_tok      (w_tok[g+1]),
            .o_key      (w_key[g])
        );
    end

    // Work out the new fill and flags when the token leaves the row
    always_comb begin
        n_fill    = r_fill;
        n_hit     = 1'b0;
        n_dropped = 1'b0;
        unique case (w_done.act)
            ACT_INSERT: begin
                if (r_fill == FILL_W'(CAPACITY)) begin
                    n_dropped = 1'b1;
                end else begin
                    n_fill = r_fill + FILL_W'(1);
                end
            end
            ACT_REMOVE: begin
                n_hit = w_done.found;
                if (w_done.found) begin
                    n_fill = r_fill - FILL_W'(1);
                end
            end
            ACT_FIND: begin
                n_hit = w_done.found;
            end
            ACT_CLEAR: begin
                n_fill = '0;
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
    end

    assign w_fill_ext = (FILL_W+5)'(n_fill);

    // Launch the token, track busy, and register the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inj.vld <= 1'b0;
            r_busy    <= 1'b0;
            r_fill    <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_inj.vld <= w_accept;
            r_strobe  <= w_done.vld;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_done.vld) begin
                r_busy <= 1'b0;
            end
            if (w_done.vld) begin
                r_fill <= n_fill;
            end
        end
        if (w_accept) begin
            r_inj.act   <= t_action'(i_action);
            r_inj.key   <= KEY_W'(i_key);
            r_inj.found <= 1'b0;
        end
        if (w_done.vld) begin
            r_hit      <= n_hit;
            r_dropped  <= n_dropped;
            r_is_empty <= (n_fill == '0);
            r_head_key <= (n_fill == '0) ? '0 : w_key[0];
            r_count    <= w_fill_ext[4:0];
        end
    end

    assign busy       = r_busy;
    assign o_strobe   = r_strobe;
    assign o_hit      = r_hit;
    assign o_dropped  = r_dropped;
    assign o_is_empty = r_is_empty;
    assign o_head_key = signed'(r_head_key);
    assign o_count    = r_count;

endmodule

// File: hdl/olt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_cell: one entry of the ordered list
// Holds one key. When the token passes, compares, takes an appended key, or
// pulls its right neighbor's key to close the gap after a removal.
// ----------------------------------------------------------------------------
module olt_cell #(
    parameter int INDEX  = 0,
    parameter int FILL_W = 5
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  olt_pkg::t_token         i_tok,
    input  logic [FILL_W-1:0]       i_fill,
    input  logic [olt_pkg::KEY_W-1:0] i_next_key,
    output olt_pkg::t_token         o_tok,
    output logic [olt_pkg::KEY_W-1:0] o_key
);
    import olt_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    t_token           r_tok;
    t_token           n_tok;
    logic             w_live;
    logic             w_match;

    // Entry holds a key only below the fill mark
    assign w_live  = FILL_W'(INDEX) < i_fill;
    assign w_match = w_live && (r_key == i_tok.key);

    // Decide the entry update and the token handed on
    always_comb begin
        n_key       = r_key;
        n_tok       = i_tok;
        n_tok.found = i_tok.found | w_match;
        if (i_tok.vld) begin
            unique case (i_tok.act)
                ACT_INSERT: begin
                    if (FILL_W'(INDEX) == i_fill) begin
                        n_key = i_tok.key;
                    end
                end
                ACT_REMOVE: begin
                    if (i_tok.found || w_match) begin
                        n_key = i_next_key;
                    end
                end
                ACT_FIND,
                ACT_CLEAR: begin
                    n_key = r_key;
                end
                default: begin
                    n_key = r_key;
                end
            endcase
        end
    end

    // Hold the key; advance the token one cell per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= i_tok.vld;
        end
        r_tok.act   <= n_tok.act;
        r_tok.key   <= n_tok.key;
        r_tok.found <= n_tok.found;
        if (i_tok.vld) begin
            r_key <= n_key;
        end
    end

    assign o_tok = r_tok;
    assign o_key = r_key;

endmodule
